FILE: rtl/core/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
// No dependencies; imported by periodic_timer_table, ptt_cmp and the testbench.
`default_nettype none

package ptt_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int TIME_W         = 32;
   localparam int SLOT_W         = 4;
   localparam int FUNC_W         = 2;
   localparam int REQ_DATA_W     = 72;
   localparam int RSP_DATA_W     = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE   = 2'd0,
      FUNC_KILL     = 2'd1,
      FUNC_KILL_ALL = 2'd2,
      FUNC_SCAN     = 2'd3
   } func_type;

   localparam logic KIND_CREATE = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/periodic_timer_table.sv
// Periodic timer table top level: slot sequencer, used bits, result register.
// Depends on ptt_pkg, ptt_ram (interval/start store) and ptt_cmp (expiry check).
//
//   channel  dir  tvalid/tready         payload
//   req_     in   item when both high   tuser: func; tdata: interval, timer_id, now
//   rsp_     out  item when both high   tuser: kind; tdata: slot; tlast: last
//
// Kill and kill-all complete in the idle state. Create walks the slots to the first
// free one, or goes straight to its answer of slot 0 on a full bank. A scan skips free
// slots, reads and compares each used slot, writes a new start for a slot that fires and
// pushes it, then flushes the last fired slot; the single RAM read port and the one
// compare unit serialize this. Reset clears all slots and the result register. A stalled
// rsp_ side holds the sequencer whenever an item must enter the occupied result register.
`default_nettype none

module periodic_timer_table #(
   parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [1:0] func
   input  wire logic [ptt_pkg::FUNC_W-1:0]          req_tuser,
   // [31:0] interval, [35:32] timer_id, [67:36] now, [71:68] zero
   input  wire logic [ptt_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] kind
   output logic                                     rsp_tuser,
   // [3:0] slot, [7:4] zero
   output logic [ptt_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tlast
);
   import ptt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int ENT_W = 2 * TIME_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_CRSP,
      S_SREAD,
      S_SCMP,
      S_SPUSH,
      S_SFLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [NUM_TIMERS-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [TIME_W-1:0]       op_interval_ff, op_interval_in;
   logic [TIME_W-1:0]       op_now_ff, op_now_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]       hold_slot_ff, hold_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_wr_en;
   logic [ENT_W-1:0]        ram_wr_data;
   logic                    ram_rd_en;
   logic [ENT_W-1:0]        ram_rd_data;
   logic                    expired;

   logic                    req_fire;
   logic                    rsp_free;
   logic                    idx_last;
   logic [IDX_W-1:0]        idx_next;
   logic [SLOT_W-1:0]       idx_slot;
   logic [TIME_W-1:0]       req_interval;
   logic [SLOT_W-1:0]       req_timer_id;
   logic [TIME_W-1:0]       req_now;
   logic [NUM_TIMERS-1:0]   kill_mask;

   assign req_interval = req_tdata[TIME_W-1:0];
   assign req_timer_id = req_tdata[TIME_W+SLOT_W-1:TIME_W];
   assign req_now      = req_tdata[2*TIME_W+SLOT_W-1:TIME_W+SLOT_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign idx_last   = (idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign idx_next   = idx_ff + IDX_W'(1);
   assign idx_slot   = SLOT_W'(idx_ff) + SLOT_W'(1);

   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         kill_mask[i] = (req_timer_id == SLOT_W'(i + 1));
      end
   end

   ptt_ram #(
      .DATA_W (ENT_W),
      .DEPTH  (NUM_TIMERS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   ptt_cmp u_cmp (
      .now      (op_now_ff),
      .start    (ram_rd_data[TIME_W-1:0]),
      .interval (ram_rd_data[ENT_W-1:TIME_W]),
      .expired  (expired)
   );

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      op_interval_in = op_interval_ff;
      op_now_in      = op_now_ff;
      hold_valid_in  = hold_valid_ff;
      hold_slot_in   = hold_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_data    = {op_interval_ff, op_now_ff};
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_interval_in = req_interval;
               op_now_in      = req_now;
               idx_in         = '0;
               unique case (func_type'(req_tuser))
                  FUNC_CREATE: begin
                     if (count_ff == CNT_W'(NUM_TIMERS)) begin
                        hold_slot_in = '0;
                        state_in     = S_CRSP;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  FUNC_KILL: begin
                     if (|(kill_mask & used_ff)) begin
                        used_in  = used_ff & ~kill_mask;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  FUNC_KILL_ALL: begin
                     used_in  = '0;
                     count_in = '0;
                  end
                  FUNC_SCAN: begin
                     hold_valid_in = 1'b0;
                     state_in      = S_SREAD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FIND: begin
            // a free slot exists: the count check ruled out a full bank
            if (!used_ff[idx_ff]) begin
               ram_wr_en       = 1'b1;
               used_in[idx_ff] = 1'b1;
               count_in        = count_ff + CNT_W'(1);
               hold_slot_in    = idx_slot;
               state_in        = S_CRSP;
            end else begin
               idx_in = idx_next;
            end
         end
         S_CRSP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CREATE;
               rsp_slot_in  = hold_slot_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SREAD: begin
            if (used_ff[idx_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_SCMP;
            end else if (idx_last) begin
               state_in = S_SFLUSH;
            end else begin
               idx_in = idx_next;
            end
         end
         S_SCMP: begin
            if (expired) begin
               // restart the period at now
               ram_wr_en   = 1'b1;
               ram_wr_data = {ram_rd_data[ENT_W-1:TIME_W], op_now_ff};
               state_in    = S_SPUSH;
            end else if (idx_last) begin
               state_in = S_SFLUSH;
            end else begin
               idx_in   = idx_next;
               state_in = S_SREAD;
            end
         end
         S_SPUSH: begin
            // hold one fired slot back so the final one can carry last
            if (!hold_valid_ff || rsp_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FIRE;
                  rsp_slot_in  = hold_slot_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_slot_in  = idx_slot;
               if (idx_last) begin
                  state_in = S_SFLUSH;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_SREAD;
               end
            end
         end
         S_SFLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_FIRE;
               rsp_slot_in   = hold_slot_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      op_interval_ff <= op_interval_in;
      op_now_ff      <= op_now_in;
      hold_slot_ff   <= hold_slot_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W){1'b0}}, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ptt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ptt_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ptt_cmp.sv
// Expiry check shared by every slot of a scan: wrapping elapsed time vs. interval.
// Depends on ptt_pkg.
`default_nettype none

module ptt_cmp (
   input  wire logic [ptt_pkg::TIME_W-1:0] now,
   input  wire logic [ptt_pkg::TIME_W-1:0] start,
   input  wire logic [ptt_pkg::TIME_W-1:0] interval,
   output logic                            expired
);
   import ptt_pkg::*;

   logic [TIME_W-1:0] elapsed;

   // modulo 2^32 subtraction handles counter wrap
   assign elapsed = now - start;
   assign expired = (interval <= elapsed);

endmodule

`default_nettype wire

FILE: tb/periodic_timer_table_test.sv
// Self-checking testbench for the periodic timer table: create, kill, kill-all and scan.
// Depends on ptt_pkg and periodic_timer_table; predicts every result with its own timer
// bank model and checks the rsp_ stream under random idling and backpressure.
`default_nettype none

module periodic_timer_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   localparam int NUM_SLOTS      = NUM_TIMERS_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic       kind;
      logic [3:0] slot;
      logic       last;
   } timer_event_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [1:0] func
   logic [FUNC_W-1:0]     req_tuser;
   // [31:0] interval, [35:32] timer_id, [67:36] now, [71:68] zero
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] kind
   logic                  rsp_tuser;
   // [3:0] slot, [7:4] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // timer bank as the testbench sees it
   logic        slot_busy   [1:NUM_SLOTS];
   logic [31:0] slot_period [1:NUM_SLOTS];
   logic [31:0] slot_start  [1:NUM_SLOTS];

   timer_event_type pending_events[$];
   timer_event_type seen_event;

   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;
   logic [31:0] tick_now = 32'h0;

   periodic_timer_table #(.NUM_TIMERS(NUM_SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the results of one accepted item and update the bank.
   function automatic void predict_timer_events(input func_type op, input logic [31:0] period,
                                                input logic [3:0] tid, input logic [31:0] now);
      int              free_slot;
      int              fire_count;
      logic [31:0]     elapsed;
      timer_event_type ev;
      free_slot  = 0;
      fire_count = 0;
      case (op)
         FUNC_CREATE: begin
            for (int i = NUM_SLOTS; i >= 1; i--) begin
               if (!slot_busy[i]) free_slot = i;
            end
            if (free_slot != 0) begin
               slot_busy[free_slot]   = 1'b1;
               slot_period[free_slot] = period;
               slot_start[free_slot]  = now;
            end
            ev.kind = KIND_CREATE;
            ev.slot = 4'(free_slot);
            ev.last = 1'b1;
            pending_events.push_back(ev);
         end
         FUNC_KILL: begin
            if (tid >= 1 && tid <= NUM_SLOTS) slot_busy[tid] = 1'b0;
         end
         FUNC_KILL_ALL: begin
            for (int i = 1; i <= NUM_SLOTS; i++) slot_busy[i] = 1'b0;
         end
         default: begin
            for (int i = 1; i <= NUM_SLOTS; i++) begin
               elapsed = now - slot_start[i];
               if (slot_busy[i] && slot_period[i] <= elapsed) begin
                  slot_start[i] = now;
                  ev.kind = KIND_FIRE;
                  ev.slot = 4'(i);
                  ev.last = 1'b0;
                  pending_events.push_back(ev);
                  fire_count++;
               end
            end
            // mark the final fired slot of this scan
            if (fire_count > 0) begin
               ev = pending_events.pop_back();
               ev.last = 1'b1;
               pending_events.push_back(ev);
            end
         end
      endcase
   endfunction

   // Offer one item; tvalid stays high after acceptance until the next call decides.
   task automatic send_request(input func_type op, input logic [31:0] period,
                               input logic [3:0] tid, input logic [31:0] now);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {4'b0, now, tid, period};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_timer_events(op, period, tid, now);
   endtask

   // Drop valid and hold the sender until every expected result has come.
   task automatic wait_for_results;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic test_create_until_full;
      logic [31:0] periods [8];
      periods = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd10, 32'd20, 32'd30, 32'd40, 32'd50};
      tick_now = 32'hFFFF_FFF0;
      foreach (periods[i]) send_request(FUNC_CREATE, periods[i], 4'd0, tick_now);
      // full bank answers slot 0
      send_request(FUNC_CREATE, 32'h1234_5678, 4'hF, tick_now);
   endtask

   task automatic test_scan_wraparound;
      // elapsed crosses zero: 0xFFFFFFF0 to 0x8 is 24 ticks
      tick_now = 32'h0000_0008;
      send_request(FUNC_SCAN, 32'hFFFF_FFFF, 4'd0, tick_now);
      send_request(FUNC_SCAN, 32'h0, 4'd0, tick_now);
      // largest interval expires only at an elapsed time of all ones
      send_request(FUNC_SCAN, 32'h0, 4'd0, 32'hFFFF_FFEF);
      tick_now = 32'hFFFF_FFEF;
   endtask

   task automatic test_kill_requests;
      send_request(FUNC_KILL, 32'hFFFF_FFFF, 4'd0, tick_now);
      send_request(FUNC_KILL, 32'h0, 4'd9, tick_now);
      send_request(FUNC_KILL, 32'h0, 4'd15, tick_now);
      send_request(FUNC_KILL, 32'h0, 4'd1, tick_now);
      send_request(FUNC_KILL, 32'h0, 4'd1, tick_now);
      // nothing due at the same tick: no result
      send_request(FUNC_SCAN, 32'h0, 4'd0, tick_now);
      send_request(FUNC_KILL, 32'h0, 4'd8, tick_now);
      send_request(FUNC_CREATE, 32'd3, 4'd0, tick_now);
   endtask

   task automatic test_kill_all;
      send_request(FUNC_KILL_ALL, 32'h0, 4'd0, tick_now);
      send_request(FUNC_SCAN, 32'h0, 4'd0, tick_now + 32'd100);
      send_request(FUNC_CREATE, 32'd7, 4'd0, tick_now);
      wait_for_results();
   endtask

   task automatic test_result_backpressure;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(FUNC_KILL_ALL, 32'h0, 4'd0, tick_now);
      for (int i = 0; i < NUM_SLOTS; i++) send_request(FUNC_CREATE, 32'd0, 4'd0, tick_now);
      wait_for_results();
      // receiver holds off while the sender keeps offering scans that fire every slot
      hold_cycles = 400;
      for (int i = 0; i < 12; i++) begin
         tick_now = tick_now + 32'd1;
         send_request(FUNC_SCAN, $urandom(), 4'(i), tick_now);
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      int          pick;
      logic [31:0] period;
      logic [3:0]  tid;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 3) tick_now = $urandom();
         else tick_now = tick_now + 32'($urandom_range(20));
         pick = $urandom_range(99);
         if (pick < 70) period = 32'($urandom_range(40));
         else if (pick < 85) period = 32'($urandom_range(300));
         else if (pick < 95) period = $urandom();
         else period = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         tid  = ($urandom_range(99) < 80) ? 4'($urandom_range(1, NUM_SLOTS))
                                          : 4'($urandom_range(15));
         pick = $urandom_range(99);
         if (pick < 30) send_request(FUNC_CREATE, period, tid, tick_now);
         else if (pick < 50) send_request(FUNC_KILL, period, tid, tick_now);
         else if (pick < 53) send_request(FUNC_KILL_ALL, period, tid, tick_now);
         else send_request(FUNC_SCAN, period, tid, tick_now);
      end
      wait_for_results();
   endtask

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: result with nothing expected: kind %0b slot %0d last %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            seen_event = pending_events.pop_front();
            if (rsp_tuser !== seen_event.kind || rsp_tdata !== {4'b0, seen_event.slot} ||
                rsp_tlast !== seen_event.last) begin
               $display({"%0t: mismatch: expected kind %0b slot %0d last %0b, ",
                         "got kind %0b slot %0d last %0b"},
                        $time, seen_event.kind, seen_event.slot, seen_event.last,
                        rsp_tuser, rsp_tdata, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = FUNC_CREATE;
      req_tdata  = '0;
      for (int i = 1; i <= NUM_SLOTS; i++) begin
         slot_busy[i]   = 1'b0;
         slot_period[i] = 32'h0;
         slot_start[i]  = 32'h0;
      end
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_create_until_full();
      test_scan_wraparound();
      test_kill_requests();
      test_kill_all();
      test_result_backpressure();
      test_random_traffic(45, 0, 0);
      test_random_traffic(45, 56, 0);
      test_random_traffic(45, 0, 56);
      test_random_traffic(45, 30, 30);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += pending_events.size();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
